// ===== hdl/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_pkg
// Types and constants shared by the Sobel edge magnitude datapath.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int PIX_W       = 24;     // packed RGB pixel
  localparam int CH_N        = 3;      // color channels
  localparam int ROOT_STEPS  = 8;      // result bits of the square root
  localparam int SUM_W       = 21;     // Gx^2 + Gy^2
  localparam int ROW_W       = 13;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_AW     = 4;
  localparam int CREDIT_W    = 5;
  localparam int ROW_LIMIT   = 4096;
  localparam int SAT_LIMIT   = 65280;  // 255^2 + 255, largest sum that rounds to 255

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic signed [11:0] grad_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } result_t;

endpackage

// ===== hdl/sobel_edge_magnitude_rgb.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel edge magnitude on RGB pixels, one pixel per clock.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per clock when the output side
// keeps up. Each transaction gives zero or one result; the result for pixel
// (row, col) comes out with the transaction at raster position one line and
// one pixel later, so frame_width + 1 drain transactions (in_action = 1) flush
// the last row, and out_frame_end marks the last result of the frame. Pixels
// outside the frame count as zero. The two earlier rows live in one line
// memory with a registered read; a pixel is read at acceptance and written back
// the next cycle, so one pixel per clock is sustained. A 16-entry result queue
// decouples the output, and in_stall rises only when the queue plus results in
// flight would exceed it.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_end
);

  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CMP_W  = (COL_W > 12) ? COL_W : 12;

  // configuration registers
  logic [11:0] frame_width_r;
  logic [12:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 12'd640;
      frame_height_r <= 13'd480;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[11:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp frame size
  logic [COL_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;

  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = COL_W'(1);
    end else if (CMP_W'(frame_width_r) > CMP_W'(MAX_WIDTH)) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = COL_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = ROW_W'(1);
    end else if (frame_height_r > ROW_W'(ROW_LIMIT)) begin
      eff_h = ROW_W'(ROW_LIMIT);
    end else begin
      eff_h = frame_height_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 0: position tracking and memory read
  // ------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CREDIT_W-1:0] credit_r, credit_nxt;
  logic             in_acc;
  logic [COL_W-1:0] c0, c_inc;
  logic [ROW_W-1:0] r0;
  logic             prod_a0, prod_b0, prod0, last0, mt0, mb0;
  logic [ROW_W-1:0] orow0;
  logic [COL_W-1:0] ocol0;
  pixel_t           pix0;
  logic [ADDR_W-1:0] addr0;

  assign in_stall = (credit_r >= CREDIT_W'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    c0 = col_r;
    r0 = row_r;
    if (col_r >= eff_w) begin
      c0 = '0;
      r0 = row_r + ROW_W'(1);
    end
    if ({1'b0, r0} > ({1'b0, eff_h} + 14'd1)) begin
      c0 = '0;
      r0 = '0;
    end
    prod_a0 = (c0 == '0) && (r0 >= ROW_W'(2)) && ({1'b0, r0} < ({1'b0, eff_h} + 14'd2));
    prod_b0 = (c0 != '0) && (r0 >= ROW_W'(1)) && ({1'b0, r0} < ({1'b0, eff_h} + 14'd1));
    prod0   = prod_a0 || prod_b0;
    orow0   = prod_a0 ? (r0 - ROW_W'(2)) : (r0 - ROW_W'(1));
    ocol0   = prod_a0 ? (eff_w - COL_W'(1)) : (c0 - COL_W'(1));
    last0   = prod0 && (orow0 == eff_h - ROW_W'(1)) && (ocol0 == eff_w - COL_W'(1));
    mt0     = (orow0 == '0);
    mb0     = (({1'b0, orow0} + 14'd1) >= {1'b0, eff_h});
    pix0    = '0;
    if (!in_action && (r0 < eff_h)) begin
      pix0 = {in_red, in_green, in_blue};
    end
    addr0 = c0[ADDR_W-1:0];
    // advance position
    c_inc = c0 + COL_W'(1);
    if (last0) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = r0 + ROW_W'(1);
    end else begin
      col_nxt = c_inc;
      row_nxt = r0;
    end
  end

  // ------------------------------------------------------------------
  // Line memory: two earlier rows per column, read-modify-write
  // ------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic               fwd_r;

  // stage 1 registers
  logic              v1_r, prod1_r, prod_a1_r, last1_r, mt1_r, mb1_r, c_zero1_r;
  logic [ADDR_W-1:0] addr1_r;
  pixel_t            pix1_r;
  pixel_t            window_r [9];

  pixel_t            top1, mid1;
  logic [2*PIX_W-1:0] mem_q, wr_data1;
  pixel_t            wz [9];
  pixel_t            wn [9];
  pixel_t            ew [9];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= line_mem[addr0];
    end
    if (v1_r) begin
      line_mem[addr1_r] <= wr_data1;
    end
  end

  // forward a write that lands on the entry being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= v1_r && in_acc && (addr0 == addr1_r);
    end
    fwd_data_r <= wr_data1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      v1_r     <= 1'b0;
    end else begin
      v1_r <= in_acc;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
    if (in_acc) begin
      prod1_r   <= prod0;
      prod_a1_r <= prod_a0;
      last1_r   <= last0;
      mt1_r     <= mt0;
      mb1_r     <= mb0;
      c_zero1_r <= (c0 == '0);
      addr1_r   <= addr0;
      pix1_r    <= pix0;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: window update and gradients
  // ------------------------------------------------------------------
  always_comb begin
    mem_q    = fwd_r ? fwd_data_r : rd_data_r;
    top1     = mem_q[2*PIX_W-1:PIX_W];
    mid1     = mem_q[PIX_W-1:0];
    wr_data1 = {mid1, pix1_r};
    for (int r = 0; r < 3; r++) begin
      if (c_zero1_r) begin
        wz[r*3+0] = window_r[r*3+1];
        wz[r*3+1] = window_r[r*3+2];
        wz[r*3+2] = '0;
      end else begin
        wz[r*3+0] = window_r[r*3+0];
        wz[r*3+1] = window_r[r*3+1];
        wz[r*3+2] = window_r[r*3+2];
      end
      wn[r*3+0] = wz[r*3+1];
      wn[r*3+1] = wz[r*3+2];
    end
    wn[2] = top1;
    wn[5] = mid1;
    wn[8] = pix1_r;
    for (int i = 0; i < 9; i++) begin
      ew[i] = prod_a1_r ? wz[i] : wn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        window_r[i] <= '0;
      end
    end else if (v1_r) begin
      for (int i = 0; i < 9; i++) begin
        window_r[i] <= wn[i];
      end
    end
  end

  grad_t gx1 [CH_N];
  grad_t gy1 [CH_N];

  always_comb begin
    grad_t p [9];
    for (int ch = 0; ch < CH_N; ch++) begin
      for (int i = 0; i < 9; i++) begin
        p[i] = grad_t'({4'd0, ew[i][PIX_W-1-8*ch -: 8]});
        if ((i < 3 && mt1_r) || (i >= 6 && mb1_r)) begin
          p[i] = '0;
        end
      end
      gx1[ch] = (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
      gy1[ch] = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: squares; stage 3: saturation check
  // ------------------------------------------------------------------
  logic             v2_r, last2_r, v3_r, last3_r;
  grad_t            gx2_r [CH_N];
  grad_t            gy2_r [CH_N];
  logic [SUM_W-1:0] sum3_r [CH_N];
  logic [SUM_W-1:0] sum2 [CH_N];

  always_comb begin
    logic signed [23:0] sx, sy;
    for (int ch = 0; ch < CH_N; ch++) begin
      sx       = gx2_r[ch] * gx2_r[ch];
      sy       = gy2_r[ch] * gy2_r[ch];
      sum2[ch] = sx[SUM_W-1:0] + sy[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v1_r && prod1_r;
      v3_r <= v2_r;
    end
    last2_r <= last1_r;
    last3_r <= last2_r;
    for (int ch = 0; ch < CH_N; ch++) begin
      gx2_r[ch]  <= gx1[ch];
      gy2_r[ch]  <= gy1[ch];
      sum3_r[ch] <= sum2[ch];
    end
  end

  // ------------------------------------------------------------------
  // Square root: one result bit per stage, per channel
  // ------------------------------------------------------------------
  logic        sq_v_r    [ROOT_STEPS];
  logic        sq_last_r [ROOT_STEPS];
  logic        sq_sat_r  [ROOT_STEPS][CH_N];
  logic [9:0]  sq_rem_r  [ROOT_STEPS][CH_N];
  logic [7:0]  sq_root_r [ROOT_STEPS][CH_N];
  logic [15:0] sq_s_r    [ROOT_STEPS][CH_N];

  logic        st_sat  [ROOT_STEPS][CH_N];
  logic [9:0]  st_rem  [ROOT_STEPS][CH_N];
  logic [7:0]  st_root [ROOT_STEPS][CH_N];
  logic [15:0] st_s    [ROOT_STEPS][CH_N];

  always_comb begin
    logic        in_sat;
    logic [9:0]  in_rem;
    logic [7:0]  in_root;
    logic [15:0] in_s;
    logic [11:0] rin, trial;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        if (k == 0) begin
          in_sat  = (sum3_r[ch] > SUM_W'(SAT_LIMIT));
          in_rem  = '0;
          in_root = '0;
          in_s    = in_sat ? 16'd0 : sum3_r[ch][15:0];
        end else begin
          in_sat  = sq_sat_r[k-1][ch];
          in_rem  = sq_rem_r[k-1][ch];
          in_root = sq_root_r[k-1][ch];
          in_s    = sq_s_r[k-1][ch];
        end
        rin   = {in_rem, in_s[15:14]};
        trial = {2'b00, in_root, 2'b01};
        if (rin >= trial) begin
          st_rem[k][ch]  = 10'(rin - trial);
          st_root[k][ch] = {in_root[6:0], 1'b1};
        end else begin
          st_rem[k][ch]  = rin[9:0];
          st_root[k][ch] = {in_root[6:0], 1'b0};
        end
        st_s[k][ch]   = {in_s[13:0], 2'b00};
        st_sat[k][ch] = in_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
        sq_v_r[k] <= 1'b0;
      end
    end else begin
      sq_v_r[0] <= v3_r;
      for (int k = 1; k < ROOT_STEPS; k++) begin
        sq_v_r[k] <= sq_v_r[k-1];
      end
    end
    sq_last_r[0] <= last3_r;
    for (int k = 1; k < ROOT_STEPS; k++) begin
      sq_last_r[k] <= sq_last_r[k-1];
    end
    for (int k = 0; k < ROOT_STEPS; k++) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        sq_sat_r[k][ch]  <= st_sat[k][ch];
        sq_rem_r[k][ch]  <= st_rem[k][ch];
        sq_root_r[k][ch] <= st_root[k][ch];
        sq_s_r[k][ch]    <= st_s[k][ch];
      end
    end
  end

  // round to nearest and saturate
  logic [7:0] mag [CH_N];
  result_t    push_data;

  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      if (sq_sat_r[ROOT_STEPS-1][ch]) begin
        mag[ch] = 8'd255;
      end else if (sq_rem_r[ROOT_STEPS-1][ch] > {2'b00, sq_root_r[ROOT_STEPS-1][ch]}) begin
        mag[ch] = sq_root_r[ROOT_STEPS-1][ch] + 8'd1;
      end else begin
        mag[ch] = sq_root_r[ROOT_STEPS-1][ch];
      end
    end
    push_data.red       = mag[0];
    push_data.green     = mag[1];
    push_data.blue      = mag[2];
    push_data.frame_end = sq_last_r[ROOT_STEPS-1];
  end

  // ------------------------------------------------------------------
  // Result queue and credit count
  // ------------------------------------------------------------------
  result_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CREDIT_W-1:0]  fill_r;
  logic                 push, pop;
  result_t              head;

  assign push      = sq_v_r[ROOT_STEPS-1];
  assign out_valid = (fill_r != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = fifo_r[rd_ptr_r];

  assign out_red       = head.red;
  assign out_green     = head.green;
  assign out_blue      = head.blue;
  assign out_frame_end = head.frame_end;

  always_comb begin
    credit_nxt = credit_r;
    if (in_acc && prod0) begin
      credit_nxt = credit_nxt + CREDIT_W'(1);
    end
    if (pop) begin
      credit_nxt = credit_nxt - CREDIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CREDIT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CREDIT_W'(1);
      end
    end
    if (push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
